### sv/dbl_pkg.sv
// Shared constants, CORDIC arctangent table and types for the distance and
// bearing to latitude/longitude offset pipeline. No dependencies.
package dbl_pkg;

    localparam int ANG_W = 26;
    localparam int LAT_W = 24;
    localparam int DIST_W = 24;
    localparam int CIRC_W = 26;
    localparam int QW = 41;
    localparam int TRIG_W = 32;
    localparam int CORDIC_W = 34;
    localparam int CORDIC_STEPS = 24;

    localparam logic [CIRC_W-1:0] CIRC_RESET = 26'd40030173;
    localparam logic [QW-1:0] OFFSET_LIMIT = 41'd773094113280;

    localparam int DEG_FULL = 23592960;
    localparam int DEG_HALF = 11796480;
    localparam int DEG_QUARTER = 5898240;
    localparam int ONE_Q30 = 1073741824;
    localparam int CORDIC_GAIN = 652032874;

    localparam logic signed [CORDIC_W-1:0] ATAN_Q24 [0:CORDIC_STEPS-1] = '{
        34'sd754974720, 34'sd445687602, 34'sd235489088, 34'sd119537938,
        34'sd60000934, 34'sd30029717, 34'sd15018523, 34'sd7509720,
        34'sd3754917, 34'sd1877466, 34'sd938734, 34'sd469367,
        34'sd234684, 34'sd117342, 34'sd58671, 34'sd29335,
        34'sd14668, 34'sd7334, 34'sd3667, 34'sd1833,
        34'sd917, 34'sd458, 34'sd229, 34'sd115
    };

    typedef enum logic [1:0] {
        ANG_GENERAL,
        ANG_POS90,
        ANG_NEG90,
        ANG_ZERO
    } ang_kind_t;

endpackage

### sv/dbl_sincos.sv
// Pipelined sine/cosine in Q30 of a Q16 degree angle: range reduction and fold,
// 24 CORDIC rotation stages, clamp and sign fix. Depends on dbl_pkg.
module dbl_sincos (
    input  logic                                aclk,
    input  logic                                en,
    input  logic signed [dbl_pkg::ANG_W-1:0]    angle,
    output logic signed [dbl_pkg::TRIG_W-1:0]   sin_q30,
    output logic signed [dbl_pkg::TRIG_W-1:0]   cos_q30
);
    localparam int CW = dbl_pkg::CORDIC_W;
    localparam int NS = dbl_pkg::CORDIC_STEPS;
    localparam logic signed [27:0] FULL28 = 28'(dbl_pkg::DEG_FULL);
    localparam logic signed [25:0] FULL26 = 26'(dbl_pkg::DEG_FULL);
    localparam logic signed [25:0] HALF26 = 26'(dbl_pkg::DEG_HALF);
    localparam logic signed [25:0] QUART26 = 26'(dbl_pkg::DEG_QUARTER);
    localparam logic signed [CW-1:0] ONE_W = CW'(dbl_pkg::ONE_Q30);
    localparam logic signed [CW-1:0] GAIN_W = CW'(dbl_pkg::CORDIC_GAIN);

    logic signed [27:0] ang_w;
    logic signed [27:0] red_w;
    logic [24:0]        red_reg;

    // reduce into [0, 360)
    always_comb begin
        ang_w = 28'(angle);
        if (ang_w >= FULL28) begin
            red_w = ang_w - FULL28;
        end else if (ang_w >= 28'sd0) begin
            red_w = ang_w;
        end else if (ang_w >= -FULL28) begin
            red_w = ang_w + FULL28;
        end else begin
            red_w = ang_w + FULL28 + FULL28;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            red_reg <= red_w[24:0];
        end
    end

    logic signed [25:0]   fold_w;
    logic                 neg_w;
    dbl_pkg::ang_kind_t   kind_w;

    // fold into [-90, 90]
    always_comb begin
        fold_w = $signed({1'b0, red_reg});
        neg_w = 1'b0;
        if (fold_w > HALF26) begin
            fold_w = fold_w - FULL26;
        end
        if (fold_w > QUART26) begin
            fold_w = fold_w - HALF26;
            neg_w = 1'b1;
        end else if (fold_w < -QUART26) begin
            fold_w = fold_w + HALF26;
            neg_w = 1'b1;
        end
        if (fold_w == QUART26) begin
            kind_w = dbl_pkg::ANG_POS90;
        end else if (fold_w == -QUART26) begin
            kind_w = dbl_pkg::ANG_NEG90;
        end else if (fold_w == 26'sd0) begin
            kind_w = dbl_pkg::ANG_ZERO;
        end else begin
            kind_w = dbl_pkg::ANG_GENERAL;
        end
    end

    logic signed [CW-1:0] x_reg [0:NS];
    logic signed [CW-1:0] y_reg [0:NS];
    logic signed [CW-1:0] z_reg [0:NS];
    logic                 neg_reg [0:NS];
    dbl_pkg::ang_kind_t   kind_reg [0:NS];

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= GAIN_W;
            y_reg[0]    <= '0;
            z_reg[0]    <= CW'(fold_w) <<< 8;
            neg_reg[0]  <= neg_w;
            kind_reg[0] <= kind_w;
        end
    end

    genvar i;
    generate
        for (i = 0; i < NS; i++) begin : g_step
            always_ff @(posedge aclk) begin
                if (en) begin
                    if (z_reg[i] >= 0) begin
                        x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                        y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                        z_reg[i+1] <= z_reg[i] - dbl_pkg::ATAN_Q24[i];
                    end else begin
                        x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                        y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                        z_reg[i+1] <= z_reg[i] + dbl_pkg::ATAN_Q24[i];
                    end
                    neg_reg[i+1]  <= neg_reg[i];
                    kind_reg[i+1] <= kind_reg[i];
                end
            end
        end
    endgenerate

    logic signed [CW-1:0] xc_w;
    logic signed [CW-1:0] yc_w;
    logic signed [CW-1:0] cos_w;
    logic signed [CW-1:0] sin_w;
    logic signed [dbl_pkg::TRIG_W-1:0] sin_reg;
    logic signed [dbl_pkg::TRIG_W-1:0] cos_reg;

    always_comb begin
        xc_w = x_reg[NS];
        yc_w = y_reg[NS];
        if (xc_w > ONE_W) xc_w = ONE_W;
        if (xc_w < -ONE_W) xc_w = -ONE_W;
        if (yc_w > ONE_W) yc_w = ONE_W;
        if (yc_w < -ONE_W) yc_w = -ONE_W;
        case (kind_reg[NS])
            dbl_pkg::ANG_POS90: begin
                cos_w = '0;
                sin_w = ONE_W;
            end
            dbl_pkg::ANG_NEG90: begin
                cos_w = '0;
                sin_w = -ONE_W;
            end
            dbl_pkg::ANG_ZERO: begin
                cos_w = ONE_W;
                sin_w = '0;
            end
            default: begin
                cos_w = xc_w;
                sin_w = yc_w;
            end
        endcase
        if (neg_reg[NS]) begin
            cos_w = -cos_w;
            sin_w = -sin_w;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sin_reg <= sin_w[dbl_pkg::TRIG_W-1:0];
            cos_reg <= cos_w[dbl_pkg::TRIG_W-1:0];
        end
    end

    assign sin_q30 = sin_reg;
    assign cos_q30 = cos_reg;

endmodule

### sv/dbl_div.sv
// Pipelined restoring divider: rounded (half up) quotient saturated at
// +180 degrees Q32, one quotient bit per stage. Depends on dbl_pkg.
module dbl_div #(
    parameter int NW = 64,
    parameter int DW = 32
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic [NW-1:0]           num,
    input  logic [DW-1:0]           den,
    output logic [dbl_pkg::QW-1:0]  mag
);
    localparam int QW = dbl_pkg::QW;
    localparam int HW = NW - QW;

    logic [DW-1:0] rem_reg [0:QW];
    logic [QW-1:0] quo_reg [0:QW];
    logic [DW-1:0] den_reg [0:QW];
    logic          ovf_reg [0:QW];
    logic [QW-1:0] low_reg [0:QW-1];

    logic [HW-1:0] hi_w;
    logic          ovf_w;

    assign hi_w = num[NW-1:QW];
    // quotient wider than the output field: saturate
    assign ovf_w = DW'(hi_w) >= den;

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= ovf_w ? '0 : DW'(hi_w);
            quo_reg[0] <= '0;
            den_reg[0] <= den;
            ovf_reg[0] <= ovf_w;
            low_reg[0] <= num[QW-1:0];
        end
    end

    genvar k;
    generate
        for (k = 1; k <= QW; k++) begin : g_bit
            logic [DW:0] trial;
            logic [DW:0] diff;
            logic        ge;

            assign trial = {rem_reg[k-1], low_reg[k-1][QW-k]};
            assign ge    = trial >= {1'b0, den_reg[k-1]};
            assign diff  = trial - {1'b0, den_reg[k-1]};

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
                    quo_reg[k] <= {quo_reg[k-1][QW-2:0], ge};
                    den_reg[k] <= den_reg[k-1];
                    ovf_reg[k] <= ovf_reg[k-1];
                end
            end

            if (k < QW) begin : g_low
                always_ff @(posedge aclk) begin
                    if (en) begin
                        low_reg[k] <= low_reg[k-1];
                    end
                end
            end
        end
    endgenerate

    logic          rnd_w;
    logic [QW:0]   qr_w;
    logic          sat_w;
    logic [QW-1:0] mag_reg;

    assign rnd_w = {rem_reg[QW], 1'b0} >= {1'b0, den_reg[QW]};
    assign qr_w  = {1'b0, quo_reg[QW]} + (QW+1)'(rnd_w);
    assign sat_w = ovf_reg[QW] || (qr_w > {1'b0, dbl_pkg::OFFSET_LIMIT});

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg <= sat_w ? dbl_pkg::OFFSET_LIMIT : qr_w[QW-1:0];
        end
    end

    assign mag = mag_reg;

endmodule

### sv/distance_bearing_to_latlon_offset.sv
// Top level: distance and bearing to latitude/longitude offset pipeline.
// Depends on dbl_pkg, dbl_sincos and dbl_div.
//
// Usage:
//   s_ channel: one transfer carries a reference latitude (Q16 degrees), a
//   distance (Q8 meters) and a bearing (Q16 degrees, clockwise from north).
//   m_ channel: one transfer per input, latitude and longitude offsets in
//   Q32 degrees, saturated at +/-180 degrees. Longitude is 0 at a pole.
//   cfg_ channel: writes the earth circumference in meters; write it only
//   while no item is in flight. cfg_ready is always high.
// Path: sine/cosine units, then the product stages, the dividers and one
//   output register.
// Throughput: one item per cycle unless stalled; the 41-stage dividers and the
//   24-stage CORDIC units are fully pipelined.
// Reset: clears all valid bits and loads the circumference 40030173 m.
// Stall: while m_valid is high and m_ready is low, the whole pipeline
//   holds and s_ready drops; nothing is dropped or repeated.
module distance_bearing_to_latlon_offset (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [dbl_pkg::LAT_W-1:0]    s_ref_latitude,
    input  logic [dbl_pkg::DIST_W-1:0]          s_distance_m,
    input  logic signed [dbl_pkg::ANG_W-1:0]    s_bearing,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [dbl_pkg::QW-1:0]       m_lat_offset,
    output logic signed [dbl_pkg::QW-1:0]       m_lon_offset,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dbl_pkg::CIRC_W-1:0]          cfg_data
);
    localparam int QW = dbl_pkg::QW;
    localparam int TW = dbl_pkg::TRIG_W;
    localparam int SC_LAT = 27;            // sine/cosine latency
    localparam int DIV_LAT = QW + 2;       // divider latency
    localparam int PIPE_LEN = SC_LAT + 2 + DIV_LAT + 1;

    // whole pipeline advances unless the output register is held
    logic en;
    assign en = !m_valid || m_ready;
    assign s_ready = en;
    assign cfg_ready = 1'b1;

    // circumference register
    logic [dbl_pkg::CIRC_W-1:0] circ_reg;
    logic [dbl_pkg::CIRC_W-1:0] circ_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            circ_reg <= dbl_pkg::CIRC_RESET;
        end else if (cfg_valid) begin
            circ_reg <= cfg_data;
        end
    end

    // zero circumference acts as one
    assign circ_eff = (circ_reg == '0) ? dbl_pkg::CIRC_W'(1) : circ_reg;

    // valid bits travel with the data
    logic [PIPE_LEN-1:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PIPE_LEN-2:0], s_valid};
        end
    end

    assign m_valid = vld_reg[PIPE_LEN-1];

    // sine and cosine of bearing and latitude
    logic signed [TW-1:0] sb_w, cb_w, sl_w, cl_w;

    dbl_sincos u_brg_sc (
        .aclk    (aclk),
        .en      (en),
        .angle   (s_bearing),
        .sin_q30 (sb_w),
        .cos_q30 (cb_w)
    );

    dbl_sincos u_lat_sc (
        .aclk    (aclk),
        .en      (en),
        .angle   (dbl_pkg::ANG_W'(s_ref_latitude)),
        .sin_q30 (sl_w),
        .cos_q30 (cl_w)
    );

    // hold the distance alongside the sine/cosine units
    logic [dbl_pkg::DIST_W-1:0] dist_reg [0:SC_LAT-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            dist_reg[0] <= s_distance_m;
        end
    end

    genvar d;
    generate
        for (d = 1; d < SC_LAT; d++) begin : g_dist
            always_ff @(posedge aclk) begin
                if (en) begin
                    dist_reg[d] <= dist_reg[d-1];
                end
            end
        end
    endgenerate

    // first product stage: north/east magnitudes, latitude and longitude divisors
    logic [TW-1:0] cb_abs, sb_abs, cl_abs;
    assign cb_abs = cb_w[TW-1] ? TW'(-cb_w) : TW'(cb_w);
    assign sb_abs = sb_w[TW-1] ? TW'(-sb_w) : TW'(sb_w);
    assign cl_abs = cl_w[TW-1] ? TW'(-cl_w) : TW'(cl_w);

    logic [54:0] nmag_reg, emag_reg;
    logic [56:0] lon_den_reg;
    logic [31:0] lat_den_reg;
    logic        lat_neg_reg, lon_neg_reg, pole_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            nmag_reg    <= {31'b0, dist_reg[SC_LAT-1]} * {24'b0, cb_abs[30:0]};
            emag_reg    <= {31'b0, dist_reg[SC_LAT-1]} * {24'b0, sb_abs[30:0]};
            lon_den_reg <= {31'b0, circ_eff} * {26'b0, cl_abs[30:0]};
            lat_den_reg <= {circ_eff, 6'b0};
            lat_neg_reg <= cb_w[TW-1];
            lon_neg_reg <= sb_w[TW-1] != cl_w[TW-1];
            pole_reg    <= (cl_w == '0);
        end
    end

    // second product stage: scale by 360 degrees
    logic [63:0] lat_num_reg, lon_num_reg;
    logic [56:0] lon_den2_reg;
    logic [31:0] lat_den2_reg;
    logic        lat_neg2_reg, lon_neg2_reg, pole2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            lat_num_reg  <= (64'(nmag_reg) << 8) + (64'(nmag_reg) << 6)
                          + (64'(nmag_reg) << 5) + (64'(nmag_reg) << 3);
            lon_num_reg  <= (64'(emag_reg) << 8) + (64'(emag_reg) << 6)
                          + (64'(emag_reg) << 5) + (64'(emag_reg) << 3);
            lat_den2_reg <= lat_den_reg;
            lon_den2_reg <= lon_den_reg;
            lat_neg2_reg <= lat_neg_reg;
            lon_neg2_reg <= lon_neg_reg;
            pole2_reg    <= pole_reg;
        end
    end

    // dividers
    logic [QW-1:0] lat_mag_w, lon_mag_w;

    dbl_div #(.NW(64), .DW(32)) u_lat_div (
        .aclk (aclk),
        .en   (en),
        .num  (lat_num_reg),
        .den  (lat_den2_reg),
        .mag  (lat_mag_w)
    );

    dbl_div #(.NW(88), .DW(57)) u_lon_div (
        .aclk (aclk),
        .en   (en),
        .num  ({lon_num_reg, 24'b0}),
        .den  (lon_den2_reg),
        .mag  (lon_mag_w)
    );

    // sign and pole flags ride along with the dividers
    logic [2:0] flag_reg [0:DIV_LAT-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            flag_reg[0] <= {pole2_reg, lon_neg2_reg, lat_neg2_reg};
        end
    end

    genvar f;
    generate
        for (f = 1; f < DIV_LAT; f++) begin : g_flag
            always_ff @(posedge aclk) begin
                if (en) begin
                    flag_reg[f] <= flag_reg[f-1];
                end
            end
        end
    endgenerate

    // output register: apply signs, zero longitude at a pole
    logic [QW-1:0] lat_out_reg, lon_out_reg;
    logic [2:0]    flag_w;
    assign flag_w = flag_reg[DIV_LAT-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            lat_out_reg <= flag_w[0] ? (QW'(0) - lat_mag_w) : lat_mag_w;
            if (flag_w[2]) begin
                lon_out_reg <= '0;
            end else begin
                lon_out_reg <= flag_w[1] ? (QW'(0) - lon_mag_w) : lon_mag_w;
            end
        end
    end

    assign m_lat_offset = $signed(lat_out_reg);
    assign m_lon_offset = $signed(lon_out_reg);

endmodule
